[rtl/rac_pkg.sv]
// shared types and constants for the rational arithmetic and compare unit
package rac_pkg;

  // operation codes
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_EQ  = 4'd4;
  localparam logic [3:0] OP_NE  = 4'd5;
  localparam logic [3:0] OP_LT  = 4'd6;
  localparam logic [3:0] OP_LE  = 4'd7;
  localparam logic [3:0] OP_GT  = 4'd8;
  localparam logic [3:0] OP_GE  = 4'd9;

  // input word
  typedef struct packed {
    logic        [3:0]  req_type;
    logic signed [31:0] a_num;
    logic        [30:0] a_den;
    logic signed [31:0] b_num;
    logic        [30:0] b_den;
  } rac_in_t;

  // result word
  typedef struct packed {
    logic signed [31:0] res_num;
    logic        [30:0] res_den;
    logic               cmp_true;
    logic               div_zero;
    logic               overflow;
  } rac_out_t;

  // which cross product the shared multiplier forms
  typedef enum logic [1:0] {
    MS_NONE,
    MS_FIRST,
    MS_SECOND,
    MS_THIRD
  } rac_mul_step_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_FORM,
    ST_ABS,
    ST_CHK,
    ST_GCD,
    ST_GSH,
    ST_DIVN_INIT,
    ST_DIVN,
    ST_DIVD_INIT,
    ST_DIVD,
    ST_FIN
  } rac_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic          load;
    rac_mul_step_t mul_step;
    logic          form;
    logic          absv;
    logic          gcd_step;
    logic          gsh;
    logic          div_init;
    logic          div_sel_den;
    logic          div_step;
    logic          cap_rn;
    logic          out_load;
  } rac_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_arith;
    logic den_zero;
    logic mag_zero;
    logic gcd_done;
    logic div_last;
  } rac_sts_t;

endpackage

[rtl/rac_dp.sv]
// datapath: shared multiplier, binary gcd, serial divider and result register
module rac_dp import rac_pkg::*; #(
  parameter int FIELD_WIDTH = 32
) (
  input  logic     clk,
  input  rac_in_t  in_word,
  input  rac_cmd_t cmd,
  output rac_sts_t sts,
  output rac_out_t out_word
);

  localparam logic [63:0] LIM = 64'd1 << (FIELD_WIDTH - 1);

  logic        [3:0]  op_r;
  logic signed [31:0] an_r, bn_r;
  logic        [30:0] ad_r, bd_r;
  logic signed [63:0] xa_r, xb_r, xd_r, num_r, den_r;
  logic        [63:0] mag_r, dmag_r, u_r, v_r, g_r, dvd_r, rem_r, rn_r;
  logic        [6:0]  k_r;
  logic        [5:0]  cnt_r;
  logic               neg_r;
  rac_out_t           out_r;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [63:0] num_nxt, den_nxt;
  logic        [63:0] mag_nxt, dmag_nxt;
  logic        [64:0] trial;
  logic               qbit;
  logic        [63:0] rem_nxt;
  logic               lt_ab, lt_ba, eq_ab;
  rac_out_t           res;

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_step)
      MS_FIRST: begin
        ma = {an_r[31], an_r};
        mb = (op_r == OP_MUL) ? {bn_r[31], bn_r} : {2'b00, bd_r};
      end
      MS_SECOND: begin
        ma = {2'b00, ad_r};
        mb = {bn_r[31], bn_r};
      end
      MS_THIRD: begin
        ma = {2'b00, ad_r};
        mb = {2'b00, bd_r};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  // unreduced numerator and denominator
  always_comb begin
    case (op_r)
      OP_ADD:  num_nxt = xa_r + xb_r;
      OP_SUB:  num_nxt = xa_r - xb_r;
      default: num_nxt = xa_r;
    endcase
    den_nxt = (op_r == OP_DIV) ? xb_r : xd_r;
  end

  // magnitudes
  assign mag_nxt  = num_r[63] ? 64'(-num_r) : 64'(num_r);
  assign dmag_nxt = den_r[63] ? 64'(-den_r) : 64'(den_r);

  // restoring division step
  assign trial   = {rem_r, dvd_r[63]} - {1'b0, g_r};
  assign qbit    = !trial[64];
  assign rem_nxt = qbit ? trial[63:0] : {rem_r[62:0], dvd_r[63]};

  // cross product compare
  assign lt_ab = xa_r < xb_r;
  assign lt_ba = xb_r < xa_r;
  assign eq_ab = xa_r == xb_r;

  // result word
  always_comb begin
    res = '0;
    case (op_r)
      OP_EQ: res.cmp_true = eq_ab;
      OP_NE: res.cmp_true = !eq_ab;
      OP_LT: res.cmp_true = lt_ab;
      OP_LE: res.cmp_true = !lt_ba;
      OP_GT: res.cmp_true = lt_ba;
      OP_GE: res.cmp_true = !lt_ab;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (den_r == '0) begin
          res.div_zero = 1'b1;
        end else if (mag_r == '0) begin
          res.res_den = 31'd1;
        end else if (dvd_r > LIM - 64'd1 ||
                     (neg_r ? rn_r > LIM : rn_r > LIM - 64'd1)) begin
          res.overflow = 1'b1;
        end else begin
          res.res_num = neg_r ? -rn_r[31:0] : rn_r[31:0];
          res.res_den = dvd_r[30:0];
        end
      end
      default: res = '0;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_word.req_type;
      an_r <= in_word.a_num;
      ad_r <= in_word.a_den;
      bn_r <= in_word.b_num;
      bd_r <= in_word.b_den;
    end
    case (cmd.mul_step)
      MS_FIRST:  xa_r <= prod[63:0];
      MS_SECOND: xb_r <= prod[63:0];
      MS_THIRD:  xd_r <= prod[63:0];
      default:   xd_r <= xd_r;
    endcase
    if (cmd.form) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
    if (cmd.absv) begin
      neg_r  <= num_r[63] ^ den_r[63];
      mag_r  <= mag_nxt;
      dmag_r <= dmag_nxt;
      u_r    <= mag_nxt;
      v_r    <= dmag_nxt;
      k_r    <= '0;
    end
    // binary gcd step
    if (cmd.gcd_step) begin
      if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + 7'd1;
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r >= v_r) begin
        u_r <= (u_r - v_r) >> 1;
      end else begin
        v_r <= (v_r - u_r) >> 1;
      end
    end
    if (cmd.gsh) begin
      g_r <= (u_r | v_r) << k_r;
    end
    if (cmd.cap_rn) begin
      rn_r <= dvd_r;
    end
    if (cmd.div_init) begin
      dvd_r <= cmd.div_sel_den ? dmag_r : mag_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[62:0], qbit};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 6'd1;
    end
    if (cmd.out_load) begin
      out_r <= res;
    end
  end

  // status
  assign sts.is_arith = op_r == OP_ADD || op_r == OP_SUB || op_r == OP_MUL || op_r == OP_DIV;
  assign sts.den_zero = den_r == '0;
  assign sts.mag_zero = mag_r == '0;
  assign sts.gcd_done = u_r == '0 || v_r == '0;
  assign sts.div_last = cnt_r == 6'd63;

  assign out_word = out_r;

endmodule

[rtl/rac_ctrl.sv]
// controller: sequences multiply, reduce, divide and result hand-off
module rac_ctrl import rac_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  rac_sts_t sts,
  output rac_cmd_t cmd
);

  rac_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_MUL1;
      ST_MUL1:      state_nxt = ST_MUL2;
      ST_MUL2:      state_nxt = sts.is_arith ? ST_MUL3 : ST_FIN;
      ST_MUL3:      state_nxt = ST_FORM;
      ST_FORM:      state_nxt = ST_ABS;
      ST_ABS:       state_nxt = ST_CHK;
      ST_CHK:       state_nxt = (sts.den_zero || sts.mag_zero) ? ST_FIN : ST_GCD;
      ST_GCD:       if (sts.gcd_done) state_nxt = ST_GSH;
      ST_GSH:       state_nxt = ST_DIVN_INIT;
      ST_DIVN_INIT: state_nxt = ST_DIVN;
      ST_DIVN:      if (sts.div_last) state_nxt = ST_DIVD_INIT;
      ST_DIVD_INIT: state_nxt = ST_DIVD;
      ST_DIVD:      if (sts.div_last) state_nxt = ST_FIN;
      ST_FIN:       if (slot_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.mul_step = MS_NONE;
    case (state_r)
      ST_IDLE:      cmd.load = in_valid;
      ST_MUL1:      cmd.mul_step = MS_FIRST;
      ST_MUL2:      cmd.mul_step = MS_SECOND;
      ST_MUL3:      cmd.mul_step = MS_THIRD;
      ST_FORM:      cmd.form = 1'b1;
      ST_ABS:       cmd.absv = 1'b1;
      ST_GCD:       cmd.gcd_step = !sts.gcd_done;
      ST_GSH:       cmd.gsh = 1'b1;
      ST_DIVN_INIT: cmd.div_init = 1'b1;
      ST_DIVN:      cmd.div_step = 1'b1;
      ST_DIVD_INIT: begin
        cmd.cap_rn      = 1'b1;
        cmd.div_init    = 1'b1;
        cmd.div_sel_den = 1'b1;
      end
      ST_DIVD:      cmd.div_step = 1'b1;
      ST_FIN:       cmd.out_load = slot_free;
      default:      cmd = '0;
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;

endmodule

[rtl/rational_arith_compare_unit.sv]
// top level of the rational arithmetic and compare unit
// One word at a time. Arithmetic reduces a nonzero result by the binary gcd loop, one
// step per cycle, then by two 64-step exact divisions through one serial divider. A
// finished result sits in an output register, so the next word is taken while it
// waits. FIELD_WIDTH sets the range that a reduced result must fit before overflow
// is flagged.
module rational_arith_compare_unit import rac_pkg::*; #(
  parameter int FIELD_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rac_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output rac_out_t out_word
);

  rac_cmd_t cmd;
  rac_sts_t sts;

  // sequencer
  rac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic
  rac_dp #(
    .FIELD_WIDTH (FIELD_WIDTH)
  ) u_dp (
    .clk      (clk),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

  // a taken word blocks the input until its result is formed
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // at most one flag per result
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_word.cmp_true, out_word.div_zero, out_word.overflow}) <= 1)
    else $error("conflicting result flags");

  // error results carry a zero fraction
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.div_zero || out_word.overflow) |->
      out_word.res_num == '0 && out_word.res_den == '0)
    else $error("error result with nonzero fraction");

endmodule

[tb/tb_rational_arith_compare_unit.sv]
// testbench for the rational arithmetic and compare unit
`timescale 1ns / 100ps

module tb_rational_arith_compare_unit;
  import rac_pkg::*;

  localparam int FW = 32;
  localparam int IDLE_LIMIT = 20000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rac_in_t  in_word;
  logic     out_valid;
  logic     out_stall;
  rac_out_t out_word;

  rac_in_t  pending_words[$];
  rac_out_t expected_results[$];
  int       mismatch_count;
  int       result_count;
  int       idle_cycles;
  int       hold_left;
  bit       stim_done;
  bit       quiet_phase;
  bit       did_hold;
  bit       in_taken;
  int       op_seen[16];

  rational_arith_compare_unit #(.FIELD_WIDTH(FW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gcd by remainders on 64-bit magnitudes
  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // reduce num/den into a result word
  function automatic rac_out_t reduce_fraction(longint num, longint den);
    rac_out_t r;
    bit neg;
    logic [63:0] mag, dmag, g, rn, rd, lim;
    r = '0;
    if (den == 0) begin
      r.div_zero = 1'b1;
      return r;
    end
    neg = (num < 0) != (den < 0);
    mag = (num < 0) ? -num : num;
    dmag = (den < 0) ? -den : den;
    if (mag == 0) begin
      r.res_den = 31'd1;
      return r;
    end
    g = gcd64(mag, dmag);
    rn = mag / g;
    rd = dmag / g;
    lim = 64'd1 << (FW - 1);
    if (rd > lim - 1 || (neg ? rn > lim : rn > lim - 1)) begin
      r.overflow = 1'b1;
      return r;
    end
    r.res_num = neg ? -rn[31:0] : rn[31:0];
    r.res_den = rd[30:0];
    return r;
  endfunction

  // expected result of one input word
  function automatic rac_out_t rational_result(rac_in_t w);
    rac_out_t r;
    longint an, ad, bn, bd, ax, bx;
    r = '0;
    an = longint'(w.a_num);
    ad = longint'({33'd0, w.a_den});
    bn = longint'(w.b_num);
    bd = longint'({33'd0, w.b_den});
    ax = an * bd;
    bx = bn * ad;
    case (w.req_type)
      OP_ADD: r = reduce_fraction(ax + bx, ad * bd);
      OP_SUB: r = reduce_fraction(ax - bx, ad * bd);
      OP_MUL: r = reduce_fraction(an * bn, ad * bd);
      OP_DIV: r = reduce_fraction(ax, ad * bn);
      OP_EQ:  r.cmp_true = (ax == bx);
      OP_NE:  r.cmp_true = (ax != bx);
      OP_LT:  r.cmp_true = (ax < bx);
      OP_LE:  r.cmp_true = !(bx < ax);
      OP_GT:  r.cmp_true = (bx < ax);
      OP_GE:  r.cmp_true = !(ax < bx);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic rac_in_t make_word(logic [3:0] op, int an, int ad, int bn, int bd);
    rac_in_t w;
    w.req_type = op;
    w.a_num = an;
    w.a_den = ad[30:0];
    w.b_num = bn;
    w.b_den = bd[30:0];
    return w;
  endfunction

  // random field values biased toward small and edge magnitudes
  function automatic logic [31:0] rand_field();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 20);
      2: v = -$urandom_range(0, 20);
      3: v = {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff} ^ $urandom_range(0, 3);
      4: v = $urandom_range(0, 5000) * $urandom_range(1, 12);
      default: v = -($urandom_range(0, 5000) * $urandom_range(1, 12));
    endcase
    return v;
  endfunction

  // driver: offer the next pending word, change only at falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_words.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 29)) begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off counted here
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!did_hold && result_count == 40) begin
      did_hold <= 1'b1;
      hold_left <= 2000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_phase && ($urandom_range(0, 99) < 29);
    end
  end

  // monitor: predict on accept, check on result, watch for hangs
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(rational_result(in_word));
        op_seen[in_word.req_type]++;
      end
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result word %h", out_word);
        end else begin
          rac_out_t e;
          e = expected_results.pop_front();
          if (out_word.res_num !== e.res_num || out_word.res_den !== e.res_den ||
              out_word.cmp_true !== e.cmp_true || out_word.div_zero !== e.div_zero ||
              out_word.overflow !== e.overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected num %0d den %0d c%0b z%0b o%0b, got num %0d den %0d c%0b z%0b o%0b",
                       e.res_num, e.res_den, e.cmp_true, e.div_zero, e.overflow,
                       out_word.res_num, out_word.res_den, out_word.cmp_true,
                       out_word.div_zero, out_word.overflow);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_rational_arith_compare_unit: done, errors");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int n;
    logic [3:0] op;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    mismatch_count = 0;
    result_count = 0;
    idle_cycles = 0;
    stim_done = 1'b0;
    quiet_phase = 1'b0;
    did_hold = 1'b0;
    in_taken = 1'b0;
    hold_left = 0;

    // directed: every op, edges, divide by zero, zero denominators, overflow, zero result
    for (int k = 0; k <= 9; k++)
      pending_words.push_back(make_word(4'(k), 3, 4, -5, 6));
    pending_words.push_back(make_word(OP_DIV, 7, 3, 0, 5));
    pending_words.push_back(make_word(OP_ADD, 1, 0, 1, 2));
    pending_words.push_back(make_word(OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1));
    pending_words.push_back(make_word(OP_MUL, 32'h8000_0000, 1, -1, 1));
    pending_words.push_back(make_word(OP_MUL, 32'h8000_0000, 1, 1, 1));
    pending_words.push_back(make_word(OP_ADD, 32'h7fff_ffff, 1, 1, 1));
    pending_words.push_back(make_word(OP_SUB, 5, 7, 5, 7));
    pending_words.push_back(make_word(OP_DIV, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    pending_words.push_back(make_word(OP_EQ, 2, 4, 1, 2));
    pending_words.push_back(make_word(OP_GE, -1, 32'h7fff_ffff, 0, 32'h7fff_ffff));
    pending_words.push_back(make_word(OP_LE, 0, 0, 0, 0));
    pending_words.push_back(make_word(4'd10, 1, 1, 1, 1));
    pending_words.push_back(make_word(4'd15, -1, 32'h7fff_ffff, -1, 32'h7fff_ffff));

    // random: mostly legal ops, some unused codes and zero denominators
    for (int i = 0; i < 500; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      pending_words.push_back(make_word(op, rand_field(),
        $urandom_range(0, 30) == 0 ? 0 : rand_field() | 32'd1,
        rand_field(),
        $urandom_range(0, 30) == 0 ? 0 : rand_field() | 32'd1));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // a stretch without idling partway through
    n = 0;
    while (pending_words.size() > 0) begin
      @(posedge clk);
      n++;
      if (n == 10000) quiet_phase = 1'b1;
      if (n == 25000) quiet_phase = 1'b0;
    end
    while (in_valid) @(posedge clk);
    stim_done = 1'b1;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d results over all ten ops and unused codes; long receiver hold %0s",
             result_count, did_hold ? "applied" : "not reached");
    $display("div results seen: %0d, compare eq results seen: %0d", op_seen[OP_DIV], op_seen[OP_EQ]);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_rational_arith_compare_unit: done, clean");
    end else begin
      $display("tb_rational_arith_compare_unit: done, errors");
    end
    $finish;
  end

endmodule
